>>> hw/rtl/vgrm_pkg.sv
// ----------------------------------------------------------------------------
// Voxel grid ray march package
// Types and constants shared by the front end, the item queue, the march
// engine and the top level.
// ----------------------------------------------------------------------------
package vgrm_pkg;

  localparam int unsigned PosW    = 20;
  localparam int unsigned StepW   = 12;
  localparam int unsigned QuoW    = 11;
  localparam int unsigned DeltaW  = 13;
  localparam int unsigned OneQ10  = 1024;
  localparam int unsigned MaxStep = 2048;

  localparam logic [7:0]  RESET_EMPTY     = 8'd32;
  localparam logic [9:0]  RESET_BORDER    = 10'd51;
  localparam logic [9:0]  RESET_EPSILON   = 10'd10;
  localparam logic [14:0] RESET_THRESHOLD = 15'd164;

  localparam logic [1:0] REG_BORDER    = 2'd0;
  localparam logic [1:0] REG_EPSILON   = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;
  localparam logic [1:0] REG_EMPTY     = 2'd3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TRACE = 1'b1;

  localparam logic [1:0] OUT_MISS  = 2'd0;
  localparam logic [1:0] OUT_HIT   = 2'd1;
  localparam logic [1:0] OUT_EDGE  = 2'd2;
  localparam logic [1:0] OUT_LIMIT = 2'd3;

  typedef struct packed {
    logic [9:0]  border_width;
    logic [9:0]  step_epsilon;
    logic [14:0] direction_threshold;
    logic [7:0]  empty_code;
  } cfg_t;

  typedef struct packed {
    logic               operation;
    logic [4:0]         cell_x;
    logic [4:0]         cell_y;
    logic [3:0]         cell_z;
    logic [7:0]         cell_code;
    logic [2:0][15:0]   origin;
    logic [2:0][15:0]   dir;
  } item_t;

endpackage

>>> hw/rtl/vgrm_front.sv
// ----------------------------------------------------------------------------
// Voxel grid ray march front end
// Accepts stream items, classifies them and drops writes outside the grid.
// ----------------------------------------------------------------------------
module vgrm_front #(
  parameter int unsigned GRID_X = 32,
  parameter int unsigned GRID_Y = 32,
  parameter int unsigned GRID_Z = 16
) (
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [119:0]    s_axis_tdata,
  input  logic            s_axis_tuser,
  input  logic            engine_ready_i,
  output logic            enq_valid_o,
  input  logic            enq_ready_i,
  output vgrm_pkg::item_t enq_item_o
);

  logic in_grid;

  always_comb begin
    enq_item_o.operation = s_axis_tuser;
    enq_item_o.cell_x    = s_axis_tdata[4:0];
    enq_item_o.cell_y    = s_axis_tdata[9:5];
    enq_item_o.cell_z    = s_axis_tdata[13:10];
    enq_item_o.cell_code = s_axis_tdata[21:14];
    enq_item_o.origin[0] = s_axis_tdata[37:22];
    enq_item_o.origin[1] = s_axis_tdata[53:38];
    enq_item_o.origin[2] = s_axis_tdata[69:54];
    enq_item_o.dir[0]    = s_axis_tdata[85:70];
    enq_item_o.dir[1]    = s_axis_tdata[101:86];
    enq_item_o.dir[2]    = s_axis_tdata[117:102];
  end

  assign in_grid = (32'(s_axis_tdata[4:0]) < GRID_X) && (32'(s_axis_tdata[9:5]) < GRID_Y)
                && (32'(s_axis_tdata[13:10]) < GRID_Z);

  assign s_axis_tready = enq_ready_i && engine_ready_i;
  assign enq_valid_o   = s_axis_tvalid && s_axis_tready
                      && ((s_axis_tuser == vgrm_pkg::OP_TRACE) || in_grid);

endmodule

>>> hw/rtl/vgrm_queue.sv
// ----------------------------------------------------------------------------
// Voxel grid ray march item queue
// Two-entry queue that decouples the front end from the march engine.
// ----------------------------------------------------------------------------
module vgrm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            push_ready_o,
  input  vgrm_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_i,
  output vgrm_pkg::item_t pop_item_o
);

  vgrm_pkg::item_t slot_q [2];
  logic            wp_q;
  logic            rp_q;
  logic [1:0]      cnt_q;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_item_o   = slot_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

>>> hw/rtl/vgrm_march.sv
// ----------------------------------------------------------------------------
// Voxel grid ray march engine
// Holds the cell store, clears it after reset, applies writes and marches
// rays one step at a time with three bit-serial step dividers.
// ----------------------------------------------------------------------------
module vgrm_march #(
  parameter int unsigned GRID_X     = 32,
  parameter int unsigned GRID_Y     = 32,
  parameter int unsigned GRID_Z     = 16,
  parameter int unsigned STEP_LIMIT = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  vgrm_pkg::cfg_t  cfg_i,
  output logic            ready_o,
  input  logic            q_valid_i,
  output logic            q_pop_o,
  input  vgrm_pkg::item_t q_item_i,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [55:0]     m_axis_tdata,
  output logic [1:0]      m_axis_tuser
);

  localparam int unsigned Depth = GRID_X * GRID_Y * GRID_Z;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned SW    = $clog2(STEP_LIMIT + 1);
  localparam int unsigned PW    = vgrm_pkg::PosW;
  localparam logic signed [PW-1:0] LimX = PW'(GRID_X * vgrm_pkg::OneQ10);
  localparam logic signed [PW-1:0] LimY = PW'(GRID_Y * vgrm_pkg::OneQ10);
  localparam logic signed [PW-1:0] LimZ = PW'(GRID_Z * vgrm_pkg::OneQ10);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_CHECK, ST_EVAL, ST_DIV, ST_MIN, ST_MUL, ST_MOVE, ST_DONE
  } state_e;

  state_e                   state_q;
  logic [AW-1:0]            clr_q;
  logic [7:0]               cells [Depth];
  logic [7:0]               rd_q;
  logic signed [PW-1:0]     pos_q   [3];
  logic [15:0]              mag_q   [3];
  logic                     neg_q   [3];
  logic                     act_q   [3];
  logic                     cap_q   [3];
  logic [24:0]              rem_q   [3];
  logic [25:0]              dv_q    [3];
  logic [vgrm_pkg::QuoW-1:0] quo_q  [3];
  logic [vgrm_pkg::DeltaW-1:0] delta_q [3];
  logic [3:0]               div_cnt_q;
  logic [vgrm_pkg::StepW-1:0] step_q;
  logic [SW-1:0]            steps_q;
  logic [1:0]               res_kind_q;
  logic [7:0]               res_code_q;
  logic [1:0]               out_kind_q;
  logic [55:0]              out_data_q;
  logic                     out_valid_q;

  logic [31:0]              wr_idx;
  logic [31:0]              rd_idx;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [7:0]               mem_wdata;
  logic                     outside;
  logic [2:0]               near;
  logic [10:0]              gap     [3];
  logic [vgrm_pkg::StepW-1:0] axis_dist [3];
  logic [vgrm_pkg::StepW-1:0] s_min;
  logic [27:0]              prod    [3];
  logic [15:0]              sat     [3];

  assign ready_o       = (state_q != ST_CLEAR);
  assign q_pop_o       = (state_q == ST_IDLE) && q_valid_i;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;

  always_comb begin
    wr_idx = (32'(q_item_i.cell_z) * GRID_Y + 32'(q_item_i.cell_y)) * GRID_X
           + 32'(q_item_i.cell_x);
    rd_idx = (32'(pos_q[2][15:10]) * GRID_Y + 32'(pos_q[1][15:10])) * GRID_X
           + 32'(pos_q[0][15:10]);
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = vgrm_pkg::RESET_EMPTY;
    end else begin
      mem_we    = q_pop_o && (q_item_i.operation == vgrm_pkg::OP_WRITE);
      mem_waddr = wr_idx[AW-1:0];
      mem_wdata = q_item_i.cell_code;
    end
    outside = pos_q[0][PW-1] || pos_q[1][PW-1] || pos_q[2][PW-1]
           || (pos_q[0] >= LimX) || (pos_q[1] >= LimY) || (pos_q[2] >= LimZ);
    s_min = vgrm_pkg::StepW'(vgrm_pkg::MaxStep);
    for (int i = 0; i < 3; i++) begin
      logic [10:0] frac;
      logic [10:0] inv;
      logic [10:0] nd;
      frac    = {1'b0, pos_q[i][9:0]};
      inv     = 11'd1024 - frac;
      nd      = (frac < inv) ? frac : inv;
      near[i] = nd < {1'b0, cfg_i.border_width};
      gap[i]  = neg_q[i] ? frac : inv;
      axis_dist[i] = (act_q[i] && !cap_q[i]) ? {1'b0, quo_q[i]}
                                               : vgrm_pkg::StepW'(vgrm_pkg::MaxStep);
      if (axis_dist[i] < s_min) begin
        s_min = axis_dist[i];
      end
      prod[i] = 28'(step_q) * 28'(mag_q[i]);
      if (pos_q[i][PW-1]) begin
        sat[i] = 16'd0;
      end else if (pos_q[i] > PW'(65535)) begin
        sat[i] = 16'hFFFF;
      end else begin
        sat[i] = pos_q[i][15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cells[mem_waddr] <= mem_wdata;
    end
    if (state_q == ST_CHECK) begin
      rd_q <= cells[rd_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      steps_q     <= '0;
      div_cnt_q   <= '0;
    end else begin
      if (out_valid_q && m_axis_tready && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(Depth - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid_i && (q_item_i.operation == vgrm_pkg::OP_TRACE)) begin
            for (int i = 0; i < 3; i++) begin
              pos_q[i] <= PW'({1'b0, q_item_i.origin[i]});
              neg_q[i] <= q_item_i.dir[i][15];
              mag_q[i] <= q_item_i.dir[i][15] ? (16'd0 - q_item_i.dir[i]) : q_item_i.dir[i];
            end
            steps_q <= '0;
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (outside) begin
            res_kind_q <= vgrm_pkg::OUT_MISS;
            res_code_q <= cfg_i.empty_code;
            state_q    <= ST_DONE;
          end else begin
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (rd_q != cfg_i.empty_code) begin
            res_kind_q <= ($countones(near) >= 2) ? vgrm_pkg::OUT_EDGE : vgrm_pkg::OUT_HIT;
            res_code_q <= rd_q;
            state_q    <= ST_DONE;
          end else if (steps_q >= SW'(STEP_LIMIT)) begin
            res_kind_q <= vgrm_pkg::OUT_LIMIT;
            res_code_q <= cfg_i.empty_code;
            state_q    <= ST_DONE;
          end else begin
            for (int i = 0; i < 3; i++) begin
              act_q[i] <= mag_q[i] > {1'b0, cfg_i.direction_threshold};
              cap_q[i] <= {2'b0, gap[i], 3'b0} >= mag_q[i];
              rem_q[i] <= {gap[i], 14'b0};
              dv_q[i]  <= {mag_q[i], 10'b0};
              quo_q[i] <= '0;
            end
            div_cnt_q <= '0;
            state_q   <= ST_DIV;
          end
        end
        ST_DIV: begin
          for (int i = 0; i < 3; i++) begin
            if ({1'b0, rem_q[i]} >= dv_q[i]) begin
              rem_q[i] <= rem_q[i] - dv_q[i][24:0];
              quo_q[i] <= {quo_q[i][vgrm_pkg::QuoW-2:0], 1'b1};
            end else begin
              quo_q[i] <= {quo_q[i][vgrm_pkg::QuoW-2:0], 1'b0};
            end
            dv_q[i] <= dv_q[i] >> 1;
          end
          div_cnt_q <= div_cnt_q + 4'd1;
          if (div_cnt_q == 4'(vgrm_pkg::QuoW - 1)) begin
            state_q <= ST_MIN;
          end
        end
        ST_MIN: begin
          step_q  <= s_min + {2'b0, cfg_i.step_epsilon};
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          for (int i = 0; i < 3; i++) begin
            delta_q[i] <= prod[i][26:14];
          end
          state_q <= ST_MOVE;
        end
        ST_MOVE: begin
          for (int i = 0; i < 3; i++) begin
            pos_q[i] <= neg_q[i] ? (pos_q[i] - PW'({1'b0, delta_q[i]}))
                                 : (pos_q[i] + PW'({1'b0, delta_q[i]}));
          end
          steps_q <= steps_q + SW'(1);
          state_q <= ST_CHECK;
        end
        ST_DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= res_kind_q;
            out_data_q  <= {sat[2], sat[1], sat[0], res_code_q};
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_steps_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    steps_q <= SW'(STEP_LIMIT))
    else $error("march step count beyond limit");

  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !q_pop_o)
    else $error("item taken during clearing pass");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (div_cnt_q < 4'(vgrm_pkg::QuoW)))
    else $error("divider ran too long");
`endif

endmodule

>>> hw/rtl/voxel_grid_ray_march_unit.sv
// ----------------------------------------------------------------------------
// Voxel grid ray march unit
// Voxel grid store with a ray marcher, configured through an APB-style port.
// ----------------------------------------------------------------------------
// Items enter on the s_axis channel; tuser selects a cell write or a ray
// trace. Writes produce no result, traces produce one result on m_axis.
// A front end takes items into a two-entry queue; the march engine drains it.
// A write is applied in the engine as it is taken from the queue. A trace
// marches at most STEP_LIMIT steps; each step is set by the bit-serial step
// dividers and the cell store read.
// After reset the cell store of GRID_X*GRID_Y*GRID_Z cells (16384 by
// default) is cleared, one cell per cycle; s_axis_tready stays low until
// then, while register writes are taken as usual.
// A result waits in the output register while m_axis_tready is low; the
// engine holds its next result until that register is free, and the queue
// keeps accepting items until it is full.
// Registers: 0 border width, 1 step epsilon, 2 direction threshold,
// 3 empty code, at byte addresses 0, 4, 8 and 12.
// ----------------------------------------------------------------------------
module voxel_grid_ray_march_unit #(
  parameter int unsigned GRID_X     = 32,
  parameter int unsigned GRID_Y     = 32,
  parameter int unsigned GRID_Z     = 16,
  parameter int unsigned STEP_LIMIT = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cell_x, cell_y, cell_z, cell_code, origin_x/y/z, dir_x/y/z; zero padded
  input  logic [119:0] s_axis_tdata,
  // operation
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit_code, stop_x, stop_y, stop_z
  output logic [55:0]  m_axis_tdata,
  // outcome
  output logic [1:0]   m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  vgrm_pkg::cfg_t  cfg_q;
  vgrm_pkg::item_t enq_item;
  vgrm_pkg::item_t deq_item;
  logic            enq_valid;
  logic            enq_ready;
  logic            deq_valid;
  logic            deq_pop;
  logic            engine_ready;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.border_width        <= vgrm_pkg::RESET_BORDER;
      cfg_q.step_epsilon        <= vgrm_pkg::RESET_EPSILON;
      cfg_q.direction_threshold <= vgrm_pkg::RESET_THRESHOLD;
      cfg_q.empty_code          <= vgrm_pkg::RESET_EMPTY;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        vgrm_pkg::REG_BORDER:    cfg_q.border_width        <= pwdata[9:0];
        vgrm_pkg::REG_EPSILON:   cfg_q.step_epsilon        <= pwdata[9:0];
        vgrm_pkg::REG_THRESHOLD: cfg_q.direction_threshold <= pwdata[14:0];
        vgrm_pkg::REG_EMPTY:     cfg_q.empty_code          <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      vgrm_pkg::REG_BORDER:    prdata = {22'd0, cfg_q.border_width};
      vgrm_pkg::REG_EPSILON:   prdata = {22'd0, cfg_q.step_epsilon};
      vgrm_pkg::REG_THRESHOLD: prdata = {17'd0, cfg_q.direction_threshold};
      vgrm_pkg::REG_EMPTY:     prdata = {24'd0, cfg_q.empty_code};
      default:                 prdata = 32'd0;
    endcase
  end

  vgrm_front #(
    .GRID_X(GRID_X),
    .GRID_Y(GRID_Y),
    .GRID_Z(GRID_Z)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .engine_ready_i(engine_ready),
    .enq_valid_o   (enq_valid),
    .enq_ready_i   (enq_ready),
    .enq_item_o    (enq_item)
  );

  vgrm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (enq_valid),
    .push_ready_o(enq_ready),
    .push_item_i (enq_item),
    .pop_valid_o (deq_valid),
    .pop_i       (deq_pop),
    .pop_item_o  (deq_item)
  );

  vgrm_march #(
    .GRID_X    (GRID_X),
    .GRID_Y    (GRID_Y),
    .GRID_Z    (GRID_Z),
    .STEP_LIMIT(STEP_LIMIT)
  ) u_march (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .ready_o      (engine_ready),
    .q_valid_i    (deq_valid),
    .q_pop_o      (deq_pop),
    .q_item_i     (deq_item),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule

>>> tb/voxel_grid_ray_march_unit_tb.sv
// ----------------------------------------------------------------------------
// Voxel grid ray march unit testbench
// Writes grid cells and traces rays through the unit under several register
// settings. A behavioural march model predicts each trace result, and every
// result transfer is checked field by field in order.
// ----------------------------------------------------------------------------
module voxel_grid_ray_march_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GX = 32;
  localparam int GY = 32;
  localparam int GZ = 16;
  localparam int MARCH_LIMIT = 256;
  localparam int IDLE_LIMIT = 60000;

  typedef struct {
    bit        op;
    bit [4:0]  cx;
    bit [4:0]  cy;
    bit [3:0]  cz;
    bit [7:0]  code;
    bit [15:0] org [3];
    bit [15:0] dir [3];
  } ray_item_t;

  typedef struct {
    bit [1:0]  outcome;
    bit [7:0]  code;
    bit [15:0] stop [3];
  } ray_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // cell_x, cell_y, cell_z, cell_code, origin_x/y/z, dir_x/y/z; zero padded
  logic [119:0] s_axis_tdata = '0;
  // operation
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // hit_code, stop_x, stop_y, stop_z
  logic [55:0]  m_axis_tdata;
  // outcome
  logic [1:0]   m_axis_tuser;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  voxel_grid_ray_march_unit dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  bit [7:0]    grid_codes [GX*GY*GZ];
  bit [9:0]    border_w = vgrm_pkg::RESET_BORDER;
  bit [9:0]    step_eps = vgrm_pkg::RESET_EPSILON;
  bit [14:0]   dir_thr = vgrm_pkg::RESET_THRESHOLD;
  bit [7:0]    empty_c = vgrm_pkg::RESET_EMPTY;
  ray_item_t   pending_items [$];
  ray_result_t expected_hits [$];
  ray_item_t   cur_item;
  bit          in_taken;
  bit          quiet_in, quiet_out;
  int          in_gap, out_stall;
  int          errors;
  int          idle_cycles;

  task automatic report(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  function automatic bit near_face(int p);
    int unsigned f, dd;
    f = p & 1023;
    dd = (f < 1024 - f) ? f : 1024 - f;
    return dd < 32'(border_w);
  endfunction

  function automatic bit [15:0] clamp16(int p);
    if (p < 0) return 16'd0;
    if (p > 65535) return 16'hFFFF;
    return p[15:0];
  endfunction

  function automatic ray_result_t march_ray(ray_item_t it);
    ray_result_t r;
    int p [3];
    int d [3];
    int unsigned steps, mag, frac, gap, axis_dist, s, dl;
    int cnt;
    bit [7:0] c;
    bit done;
    for (int i = 0; i < 3; i++) begin
      p[i] = int'(it.org[i]);
      d[i] = int'($signed(it.dir[i]));
    end
    steps = 0;
    done = 0;
    while (!done) begin
      if (p[0] < 0 || p[1] < 0 || p[2] < 0 || p[0] >= GX*1024 || p[1] >= GY*1024 ||
          p[2] >= GZ*1024) begin
        r.outcome = vgrm_pkg::OUT_MISS;
        r.code = empty_c;
        done = 1;
      end else begin
        c = grid_codes[((p[2] >>> 10) * GY + (p[1] >>> 10)) * GX + (p[0] >>> 10)];
        if (c != empty_c) begin
          cnt = int'(near_face(p[0])) + int'(near_face(p[1])) + int'(near_face(p[2]));
          r.outcome = (cnt >= 2) ? vgrm_pkg::OUT_EDGE : vgrm_pkg::OUT_HIT;
          r.code = c;
          done = 1;
        end else if (steps >= MARCH_LIMIT) begin
          r.outcome = vgrm_pkg::OUT_LIMIT;
          r.code = empty_c;
          done = 1;
        end else begin
          s = 2048;
          for (int i = 0; i < 3; i++) begin
            mag = (d[i] < 0) ? -d[i] : d[i];
            if (mag > 32'(dir_thr)) begin
              frac = p[i] & 1023;
              gap = (d[i] > 0) ? 1024 - frac : frac;
              axis_dist = (gap << 14) / mag;
              if (axis_dist < s) s = axis_dist;
            end
          end
          s += 32'(step_eps);
          for (int i = 0; i < 3; i++) begin
            mag = (d[i] < 0) ? -d[i] : d[i];
            dl = (s * mag) >> 14;
            p[i] = (d[i] < 0) ? p[i] - int'(dl) : p[i] + int'(dl);
          end
          steps++;
        end
      end
    end
    for (int i = 0; i < 3; i++) r.stop[i] = clamp16(p[i]);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 50) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    if (r < 98) return int'($urandom_range(4, 15));
    return int'($urandom_range(30, 120));
  endfunction

  // Input driver
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || in_taken) begin
      if ($urandom_range(0, 63) == 0) quiet_in = !quiet_in;
      if (in_gap > 0) begin
        in_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        cur_item = pending_items.pop_front();
        s_axis_tdata <= {2'b00, cur_item.dir[2], cur_item.dir[1], cur_item.dir[0],
                         cur_item.org[2], cur_item.org[1], cur_item.org[0],
                         cur_item.code, cur_item.cz, cur_item.cy, cur_item.cx};
        s_axis_tuser <= cur_item.op;
        s_axis_tvalid <= 1'b1;
        in_gap = quiet_in ? 0 : pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver
  always @(negedge clk_i) begin
    if ($urandom_range(0, 255) == 0) quiet_out = !quiet_out;
    if (out_stall > 0) begin
      out_stall--;
      m_axis_tready <= 1'b0;
    end else if (!quiet_out && $urandom_range(0, 7) == 0) begin
      out_stall = pick_gap();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor and predictor
  always @(posedge clk_i) begin
    ray_result_t want;
    in_taken = s_axis_tvalid && s_axis_tready;
    idle_cycles++;
    if (in_taken) begin
      idle_cycles = 0;
      if (cur_item.op == vgrm_pkg::OP_TRACE) begin
        expected_hits.push_back(march_ray(cur_item));
      end else begin
        grid_codes[(int'(cur_item.cz) * GY + int'(cur_item.cy)) * GX + int'(cur_item.cx)] =
          cur_item.code;
      end
    end
    if (m_axis_tvalid && m_axis_tready) begin
      idle_cycles = 0;
      if (expected_hits.size() == 0) begin
        report("unexpected result", 32'(m_axis_tuser), 0);
      end else begin
        want = expected_hits.pop_front();
        if (m_axis_tuser != want.outcome)
          report("outcome", 32'(m_axis_tuser), 32'(want.outcome));
        if (m_axis_tdata[7:0] != want.code)
          report("hit_code", 32'(m_axis_tdata[7:0]), 32'(want.code));
        if (m_axis_tdata[23:8] != want.stop[0])
          report("stop_x", 32'(m_axis_tdata[23:8]), 32'(want.stop[0]));
        if (m_axis_tdata[39:24] != want.stop[1])
          report("stop_y", 32'(m_axis_tdata[39:24]), 32'(want.stop[1]));
        if (m_axis_tdata[55:40] != want.stop[2])
          report("stop_z", 32'(m_axis_tdata[55:40]), 32'(want.stop[2]));
      end
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      vgrm_pkg::REG_BORDER:    border_w = val[9:0];
      vgrm_pkg::REG_EPSILON:   step_eps = val[9:0];
      vgrm_pkg::REG_THRESHOLD: dir_thr = val[14:0];
      default:                 empty_c = val[7:0];
    endcase
  endtask

  task automatic set_regs(int bw, int eps, int thr, int ec);
    reg_write(vgrm_pkg::REG_BORDER, 32'(bw));
    reg_write(vgrm_pkg::REG_EPSILON, 32'(eps));
    reg_write(vgrm_pkg::REG_THRESHOLD, 32'(thr));
    reg_write(vgrm_pkg::REG_EMPTY, 32'(ec));
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || s_axis_tvalid || expected_hits.size() != 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic add_write(int x, int y, int z, int code);
    ray_item_t it;
    it.op = vgrm_pkg::OP_WRITE;
    it.cx = 5'(x);
    it.cy = 5'(y);
    it.cz = 4'(z);
    it.code = 8'(code);
    for (int i = 0; i < 3; i++) begin
      it.org[i] = 16'($urandom);
      it.dir[i] = 16'($urandom);
    end
    pending_items.push_back(it);
  endtask

  task automatic add_trace(int ox, int oy, int oz, int dx, int dy, int dz);
    ray_item_t it;
    it.op = vgrm_pkg::OP_TRACE;
    it.cx = 5'($urandom);
    it.cy = 5'($urandom);
    it.cz = 4'($urandom);
    it.code = 8'($urandom);
    it.org[0] = 16'(ox);
    it.org[1] = 16'(oy);
    it.org[2] = 16'(oz);
    it.dir[0] = 16'(dx);
    it.dir[1] = 16'(dy);
    it.dir[2] = 16'(dz);
    pending_items.push_back(it);
  endtask

  function automatic int rand_coord(int cells);
    int v;
    case ($urandom_range(0, 15))
      0: v = int'($urandom_range(0, 65535));
      1, 2, 3: v = int'($urandom_range(0, cells - 1)) * 1024;
      default: v = int'($urandom_range(0, cells * 1024 - 1));
    endcase
    return v;
  endfunction

  function automatic int rand_dir(int kind);
    case (kind)
      0: return int'($urandom_range(0, 300)) - 150;
      1: return ($urandom_range(0, 2) == 0) ? 0 :
                (($urandom_range(0, 1) != 0) ? 16384 : -16384);
      default: return int'($urandom_range(0, 32768)) - 16384;
    endcase
  endfunction

  task automatic add_random(int items);
    int kind;
    for (int n = 0; n < items; n++) begin
      if ($urandom_range(0, 99) < 40) begin
        add_write(int'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 31)
                                                   : $urandom_range(0, 15)),
                  int'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 31)
                                                   : $urandom_range(0, 15)),
                  int'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 15)
                                                   : $urandom_range(0, 7)),
                  int'(($urandom_range(0, 7) == 0) ? 32 : $urandom_range(0, 255)));
      end else begin
        kind = ($urandom_range(0, 39) == 0) ? 0 : (($urandom_range(0, 5) == 0) ? 1 : 2);
        add_trace(rand_coord(16), rand_coord(16), rand_coord(8),
                  rand_dir(kind), rand_dir(kind), rand_dir(kind));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < GX*GY*GZ; i++) grid_codes[i] = vgrm_pkg::RESET_EMPTY;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    set_regs(int'(vgrm_pkg::RESET_BORDER), int'(vgrm_pkg::RESET_EPSILON),
             int'(vgrm_pkg::RESET_THRESHOLD), int'(vgrm_pkg::RESET_EMPTY));
    add_write(0, 0, 0, 200);
    add_write(31, 31, 15, 7);
    add_write(5, 5, 3, 255);
    add_write(20, 16, 8, 1);
    add_trace(0, 0, 0, 16384, 0, 0);
    add_trace(32256, 32256, 15872, -16384, 0, 0);
    add_trace(5120, 5120, 3584, 0, 0, 16384);
    add_trace(65535, 1024, 1024, 16384, 0, 0);
    add_trace(1024, 32768, 1024, 0, 16384, 0);
    add_trace(1024, 1024, 16384, 0, 0, 16384);
    add_trace(10752, 10752, 10752, 10, -10, 0);
    add_trace(10752, 16896, 8704, 16384, 0, 0);
    add_trace(1536, 20992, 8704, 16384, 0, 0);
    add_trace(16896, 16896, 8704, -16384, 0, 0);
    add_trace(16896, 16896, 8704, 0, 16384, 0);
    add_trace(16896, 3584, 8704, 0, -16384, 0);
    add_trace(16896, 3584, 8704, 0, 0, 16384);
    add_trace(3584, 3584, 8704, 0, 0, -16384);
    add_trace(512, 512, 512, 9459, 9459, 9459);
    add_trace(30000, 30000, 15000, -9459, -9459, -9459);
    add_trace(20000, 9000, 5000, -1, 16383, -16384);
    add_write(0, 0, 0, 32);
    add_trace(0, 0, 0, -16384, 0, 0);
    wait_drained();

    set_regs(0, 0, 0, 0);
    add_random(100);
    wait_drained();
    set_regs(1023, 1023, 16384, 255);
    add_random(100);
    wait_drained();
    for (int ph = 0; ph < 5; ph++) begin
      set_regs(int'($urandom_range(0, 200)), int'($urandom_range(0, 60)),
               int'($urandom_range(0, 2000)),
               int'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : 32));
      add_random(140);
      wait_drained();
    end
    set_regs(int'(vgrm_pkg::RESET_BORDER), int'(vgrm_pkg::RESET_EPSILON),
             int'(vgrm_pkg::RESET_THRESHOLD), int'(vgrm_pkg::RESET_EMPTY));
    add_random(180);
    wait_drained();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
